[sv/ptpd_pkg.sv]
// Shared types, codes and helpers for the point to polyline distance block.
package ptpd_pkg;

  // Coordinate width of the Q16.16 fields.
  localparam int COORD_BITS = 32;
  // Accumulator width: three 66-bit squares plus sign and headroom for division.
  localparam int ACC_W = 70;
  // Root width of the square root of an accumulator value.
  localparam int ROOT_W = ACC_W / 2;
  localparam int REM_W = ROOT_W + 3;
  // Bit counter width for the serial scaling division.
  localparam int BIT_W = $clog2(COORD_BITS);
  // Last product step of the segment pass and of the offset pass.
  localparam logic [3:0] MUL_SEG_LAST = 4'd8;
  localparam logic [3:0] MUL_T_LAST = 4'd2;

  // Item kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Axis drop codes.
  localparam logic [1:0] DROP_NONE = 2'd0;
  localparam logic [1:0] DROP_X = 2'd1;
  localparam logic [1:0] DROP_Y = 2'd2;
  localparam logic [1:0] DROP_Z = 2'd3;

  typedef struct packed {
    logic                         action;
    logic [7:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [1:0]                   drop_axis;
  } ptpd_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]        distance;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
    logic signed [COORD_BITS-1:0] closest_z;
    logic                         found;
  } ptpd_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_CAP_A,
    S_RD_B,
    S_CAP_B,
    S_MUL,
    S_ACC,
    S_CLASS,
    S_DIV,
    S_DFIN,
    S_CMP,
    S_SQRT,
    S_FIN
  } ptpd_state_t;

  // Accumulator that a product is added into.
  typedef enum logic [1:0] {
    DST_DD,
    DST_EE,
    DST_DOT,
    DST_D2
  } ptpd_dst_t;

  // True when axis k is the one the query drops.
  function automatic logic drop_hit(logic [1:0] drop, logic [1:0] k);
    return (drop == DROP_X && k == 2'd0) || (drop == DROP_Y && k == 2'd1) ||
           (drop == DROP_Z && k == 2'd2);
  endfunction

endpackage

[sv/point_to_polyline_distance.sv]
// Top level of the point to polyline distance block.
//
// Channels: an item is taken when start is high and busy is low. A load item
// (action 0) writes one vertex into the store in that same cycle and leaves
// busy low, so loads may follow back to back. A query item (action 1) raises
// busy and walks every segment of the polyline on one shared 33 by 33 bit
// multiplier, a serial scaling divider and a serial square root. Its result
// appears on result for exactly one cycle with result_valid high; the
// receiver cannot stall, so it must take the result in that cycle.
// The vertex count register is written through cfg_valid and cfg_ready while
// the block is idle.
// Course of a query: with fewer than two vertices in use it goes straight to the
// final state; otherwise it reads the first vertex and then, per segment, reads
// the end vertex and forms the segment products; three more products follow
// when the end vertex is nearest, and three 32-step divisions and three more
// products when the foot point is nearest. A 35-step root and the result close
// the query. The serial divider sets the worst case. Reset clears the sequencer
// and the vertex count; the vertex store keeps no reset and must be loaded
// before it is queried.
module point_to_polyline_distance import ptpd_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ptpd_in_t  cmd,
  output logic      result_valid,
  output ptpd_out_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [8:0] cfg_data
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam int VW = 3 * COORD_BITS;

  ptpd_state_t state, state_next;

  logic [8:0]  vertex_count;
  logic [NW-1:0] nvert;
  logic [IW-1:0] seg;
  logic        have_seg;
  logic [1:0]  drop;

  logic signed [COORD_BITS-1:0] pnt [3];
  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] cl [3];
  logic signed [COORD_BITS-1:0] bcl [3];
  logic [COORD_BITS-1:0] dm [3];
  logic [COORD_BITS-1:0] em [3];
  logic        dneg [3];
  logic        eneg [3];
  logic [COORD_BITS:0] tm [3];

  logic signed [ACC_W-1:0] dd, ee, dot, d2, best;
  logic [3:0]  mstep;
  logic        tphase;
  logic [COORD_BITS*2+1:0] prod;
  logic        prod_neg;
  ptpd_dst_t   prod_dst;

  logic [1:0]  kdiv;
  logic [BIT_W-1:0] bitc;
  logic [ACC_W-1:0] rdiv;
  logic [COORD_BITS-1:0] qdiv;

  logic [ACC_W-1:0] sq_src;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [5:0]  sq_cnt;

  logic        accept, wr_en, rd_en;
  logic [IW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  logic [COORD_BITS:0] opa, opb;
  logic        op_neg;
  ptpd_dst_t   op_dst;
  logic        mul_last;

  assign busy = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept = start && !busy;
  assign wr_en = accept && cmd.action == ACT_LOAD &&
                 32'(cmd.vertex_index) < MAX_VERTICES;

  ptpd_vstore #(
    .DEPTH (MAX_VERTICES),
    .AW    (IW),
    .W     (VW)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(cmd.vertex_index)),
    .wr_data ({cmd.pos_x, cmd.pos_y, cmd.pos_z}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Vertex count in use, limited to the store depth.
  function automatic logic [NW-1:0] nvert_calc(logic [8:0] cnt);
    logic [NW-1:0] c;
    c = NW'(cnt);
    return (c > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : c;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    op_neg = 1'b0;
    op_dst = DST_D2;
    if (tphase) begin
      opa = tm[mstep[1:0]];
      opb = tm[mstep[1:0]];
    end else begin
      unique case (mstep)
        4'd0, 4'd1, 4'd2: begin
          opa = {1'b0, dm[mstep[1:0]]};
          opb = {1'b0, dm[mstep[1:0]]};
          op_dst = DST_DD;
        end
        4'd3, 4'd4, 4'd5: begin
          opa = {1'b0, em[2'(mstep - 4'd3)]};
          opb = {1'b0, em[2'(mstep - 4'd3)]};
          op_dst = DST_EE;
        end
        4'd6, 4'd7, 4'd8: begin
          opa = {1'b0, dm[2'(mstep - 4'd6)]};
          opb = {1'b0, em[2'(mstep - 4'd6)]};
          op_neg = dneg[2'(mstep - 4'd6)] ^ eneg[2'(mstep - 4'd6)];
          op_dst = DST_DOT;
        end
        default: begin
          opa = '0;
        end
      endcase
    end
    mul_last = tphase ? (mstep == MUL_T_LAST) : (mstep == MUL_SEG_LAST);
  end

  // Next state and store read control.
  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = seg;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.action == ACT_QUERY) begin
          state_next = (nvert_calc(vertex_count) < NW'(2)) ? S_FIN : S_RD_A;
        end
      end
      S_RD_A: begin
        rd_en = 1'b1;
        rd_addr = '0;
        state_next = S_CAP_A;
      end
      S_CAP_A: state_next = S_RD_B;
      S_RD_B: begin
        rd_en = 1'b1;
        state_next = S_CAP_B;
      end
      S_CAP_B: state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (!mul_last) begin
          state_next = S_MUL;
        end else if (tphase) begin
          state_next = S_CMP;
        end else begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (dd == '0 || ee == '0 || dot <= 0) begin
          state_next = S_CMP;
        end else if (dot > dd) begin
          state_next = S_MUL;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: state_next = (bitc == '0) ? S_DFIN : S_DIV;
      S_DFIN: state_next = (kdiv == 2'd2) ? S_MUL : S_DIV;
      S_CMP: begin
        state_next = ({{(NW-IW){1'b0}}, seg} == nvert - NW'(1)) ? S_SQRT : S_RD_B;
      end
      S_SQRT: state_next = (sq_cnt == '0) ? S_FIN : S_SQRT;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    logic signed [COORD_BITS:0] dv, ev;
    logic signed [ACC_W-1:0] addend, acc_in, sum;
    logic [ACC_W-1:0] r2, dd2;
    logic [1:0] inc;
    logic signed [COORD_BITS+1:0] off, et, tt;
    logic [REM_W-1:0] rem_s, trial;
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_FIN);
    end
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.action == ACT_QUERY) begin
          pnt[0] <= cmd.pos_x;
          pnt[1] <= cmd.pos_y;
          pnt[2] <= cmd.pos_z;
          drop <= cmd.drop_axis;
          nvert <= nvert_calc(vertex_count);
          have_seg <= nvert_calc(vertex_count) >= NW'(2);
          seg <= IW'(1);
        end
      end
      S_CAP_A: begin
        va[0] <= rd_data[VW-1 -: COORD_BITS];
        va[1] <= rd_data[VW-COORD_BITS-1 -: COORD_BITS];
        va[2] <= rd_data[COORD_BITS-1:0];
      end
      // Take the end vertex and form the segment and point offsets.
      S_CAP_B: begin
        vb[0] <= rd_data[VW-1 -: COORD_BITS];
        vb[1] <= rd_data[VW-COORD_BITS-1 -: COORD_BITS];
        vb[2] <= rd_data[COORD_BITS-1:0];
        for (int k = 0; k < 3; k++) begin
          dv = (COORD_BITS+1)'($signed(rd_data[VW-1-k*COORD_BITS -: COORD_BITS])) -
               (COORD_BITS+1)'(va[k]);
          ev = (COORD_BITS+1)'(pnt[k]) - (COORD_BITS+1)'(va[k]);
          if (drop_hit(drop, 2'(k))) begin
            dv = '0;
            ev = '0;
          end
          dneg[k] <= dv[COORD_BITS];
          eneg[k] <= ev[COORD_BITS];
          dm[k] <= dv[COORD_BITS] ? COORD_BITS'(-dv) : dv[COORD_BITS-1:0];
          em[k] <= ev[COORD_BITS] ? COORD_BITS'(-ev) : ev[COORD_BITS-1:0];
        end
        dd <= '0;
        ee <= '0;
        dot <= '0;
        mstep <= '0;
        tphase <= 1'b0;
      end
      S_MUL: begin
        prod <= opa * opb;
        prod_neg <= op_neg;
        prod_dst <= op_dst;
      end
      // Shared accumulate of the registered product.
      S_ACC: begin
        addend = prod_neg ? -ACC_W'(prod) : ACC_W'(prod);
        unique case (prod_dst)
          DST_DD: acc_in = dd;
          DST_EE: acc_in = ee;
          DST_DOT: acc_in = dot;
          DST_D2: acc_in = d2;
        endcase
        sum = acc_in + addend;
        unique case (prod_dst)
          DST_DD: dd <= sum;
          DST_EE: ee <= sum;
          DST_DOT: dot <= sum;
          DST_D2: d2 <= sum;
        endcase
        mstep <= mstep + 4'd1;
      end
      // Behind the start, past the end, or onto the segment.
      S_CLASS: begin
        priority if (dd == '0 || ee == '0 || dot <= 0) begin
          d2 <= ee;
          cl <= va;
        end else if (dot > dd) begin
          for (int k = 0; k < 3; k++) begin
            ev = (COORD_BITS+1)'(pnt[k]) - (COORD_BITS+1)'(vb[k]);
            if (drop_hit(drop, 2'(k))) begin
              ev = '0;
            end
            tm[k] <= {1'b0, ev[COORD_BITS] ? COORD_BITS'(-ev) : ev[COORD_BITS-1:0]};
          end
          cl <= vb;
          d2 <= '0;
          mstep <= '0;
          tphase <= 1'b1;
        end else begin
          kdiv <= '0;
          bitc <= BIT_W'(COORD_BITS - 1);
          rdiv <= '0;
          qdiv <= '0;
        end
      end
      // One bit of floor(|d| * dot / dd); the remainder stays below dd.
      S_DIV: begin
        r2 = {rdiv[ACC_W-2:0], 1'b0} + (dm[kdiv][bitc] ? $unsigned(dot) : '0);
        dd2 = {dd[ACC_W-2:0], 1'b0};
        priority if (r2 >= dd2) begin
          r2 = r2 - dd2;
          inc = 2'd2;
        end else if (r2 >= $unsigned(dd)) begin
          r2 = r2 - $unsigned(dd);
          inc = 2'd1;
        end else begin
          inc = 2'd0;
        end
        rdiv <= r2;
        qdiv <= {qdiv[COORD_BITS-2:0], 1'b0} + COORD_BITS'(inc);
        bitc <= bitc - BIT_W'(1);
      end
      // Foot point offset for one axis.
      S_DFIN: begin
        off = {2'b00, qdiv};
        if (dneg[kdiv]) begin
          off = -off;
        end
        et = {2'b00, em[kdiv]};
        if (eneg[kdiv]) begin
          et = -et;
        end
        tt = et - off;
        tm[kdiv] <= tt[COORD_BITS+1] ? (COORD_BITS+1)'(-tt) : tt[COORD_BITS:0];
        cl[kdiv] <= drop_hit(drop, kdiv) ? pnt[kdiv] : va[kdiv] + off[COORD_BITS-1:0];
        kdiv <= kdiv + 2'd1;
        bitc <= BIT_W'(COORD_BITS - 1);
        rdiv <= '0;
        qdiv <= '0;
        d2 <= '0;
        mstep <= '0;
        tphase <= 1'b1;
      end
      // Keep the first strictly smallest segment and step on.
      S_CMP: begin
        if (seg == IW'(1) || d2 < best) begin
          best <= d2;
          bcl <= cl;
        end
        va <= vb;
        seg <= seg + IW'(1);
        sq_src <= (seg == IW'(1) || d2 < best) ? $unsigned(d2) : $unsigned(best);
        root <= '0;
        rem <= '0;
        sq_cnt <= 6'(ROOT_W - 1);
      end
      // One root bit a cycle.
      S_SQRT: begin
        rem_s = {rem[REM_W-3:0], sq_src[ACC_W-1 -: 2]};
        trial = REM_W'({root, 2'b01});
        if (rem_s >= trial) begin
          rem <= rem_s - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= rem_s;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sq_src <= {sq_src[ACC_W-3:0], 2'b00};
        sq_cnt <= sq_cnt - 6'd1;
      end
      S_FIN: begin
        if (have_seg) begin
          result.distance <= (|root[ROOT_W-1:COORD_BITS]) ? '1 : root[COORD_BITS-1:0];
          result.closest_x <= bcl[0];
          result.closest_y <= bcl[1];
          result.closest_z <= bcl[2];
          result.found <= 1'b1;
        end else begin
          result.distance <= '1;
          result.closest_x <= '0;
          result.closest_y <= '0;
          result.closest_z <= '0;
          result.found <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // A result is given only after the walk has finished.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> !busy)
    else $error("result strobe while the walk is still running");

  // Without a segment the distance is saturated.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.distance == '1)
    else $error("no-segment result without saturated distance");

  // A query always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.action == ACT_QUERY |=> busy)
    else $error("query item did not start the walk");

  // A load item never occupies the block.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.action == ACT_LOAD |=> !busy)
    else $error("load item left the block busy");

endmodule

[sv/ptpd_vstore.sv]
// Vertex store: one write port and one registered read port.
module ptpd_vstore import ptpd_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int W = 96
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // Write a vertex word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
